// File: rtl/core/ffc_pkg.sv
// shared types, format codes and a conversion function for the format cast unit
package ffc_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned FmtW = 3;

  typedef enum logic [FmtW-1:0] {
    FMT_FP32 = 3'd1,
    FMT_FP16 = 3'd2,
    FMT_INT8 = 3'd3,
    FMT_BF16 = 3'd4
  } fmt_e_t;

  localparam logic [0:0] CFG_SRC = 1'b0;
  localparam logic [0:0] CFG_DST = 1'b1;

  typedef enum logic [2:0] {
    OP_PASS, OP_F32_F16, OP_F16_F32, OP_I8_F32, OP_F32_BF16, OP_BF16_F32, OP_I8_F16, OP_BAD
  } op_t;

  // fp32 to fp16, truncating
  function automatic logic [15:0] f32_to_f16(input logic [31:0] x);
    logic [7:0] ex;
    logic [22:0] man;
    logic [15:0] s;
    logic signed [9:0] ne;
    logic [23:0] full;
    logic [4:0] sh;
    logic [23:0] shv;
    begin
      ex = x[30:23];
      man = x[22:0];
      s = {x[31], 15'd0};
      ne = $signed({2'b00, ex}) - 10'sd112;
      full = {1'b1, man};
      sh = 5'(10'sd14 - ne);
      shv = full >> sh;
      if (ex == 8'd0) f32_to_f16 = s;
      else if (ex == 8'hFF) f32_to_f16 = s | 16'h7C00 | ((man != 23'd0) ? 16'h0200 : 16'h0);
      else if (ne >= 10'sd31) f32_to_f16 = s | 16'h7C00;
      else if (ne <= 10'sd0) begin
        if (ne >= -10'sd10) f32_to_f16 = s | {6'd0, shv[9:0]};
        else f32_to_f16 = s;
      end else f32_to_f16 = s | {1'b0, ne[4:0], man[22:13]};
    end
  endfunction

endpackage

// File: rtl/core/ffc_if.sv
// valid/ready word channel
interface ffc_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        unsupported;
  modport source (output valid, input ready, output value, output unsupported);
  modport sink (input valid, output ready, input value, input unsupported);
endinterface

// File: rtl/core/ffc_norm.sv
// leading-one normalization of an 11-bit magnitude into fp32 fields
module ffc_norm
  import ffc_pkg::*;
(
  input  logic [10:0] mag,
  output logic [3:0]  pos,
  output logic [22:0] frac
);
  always_comb begin
    pos = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (mag[i]) pos = 4'(i);
    end
    frac = 23'({12'd0, mag} << (5'd23 - {1'b0, pos}));
  end
endmodule

// File: rtl/core/float_format_cast_unit.sv
// top level of the format cast unit
// path: an accepted input word reaches out through the stage 1, 2 and 3 registers
// throughput: one word per cycle; three register stages advance together, so the
//   whole pipe, bubbles included, holds while a result word waits on out.ready low
// reset: synchronous active-low rst_n clears valid bits; formats return to fp32/fp32
module float_format_cast_unit
  import ffc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ffc_if.sink           in_ch,
  ffc_if.source         out_ch,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [FmtW-1:0] cfg_data
);
  logic [FmtW-1:0] src_r, dst_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= FMT_FP32;
      dst_r <= FMT_FP32;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SRC) src_r <= cfg_data;
      else dst_r <= cfg_data;
    end
  end

  logic v1_r, v2_r, v3_r;
  logic adv;
  // whole pipe moves when the last slot empties or is taken
  assign adv = !v3_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: decode op, capture input word masked to the source width
  op_t op_nxt, op1_r, op2_r;
  logic [31:0] x1_r;
  logic [31:0] mask;
  always_comb begin
    mask = 32'hFFFF_FFFF;
    if (src_r == FMT_FP16 || src_r == FMT_BF16) mask = 32'h0000_FFFF;
    else if (src_r == FMT_INT8) mask = 32'h0000_00FF;
    if (src_r == dst_r) op_nxt = OP_PASS;
    else if (src_r == FMT_FP32 && dst_r == FMT_FP16) op_nxt = OP_F32_F16;
    else if (src_r == FMT_FP16 && dst_r == FMT_FP32) op_nxt = OP_F16_F32;
    else if (src_r == FMT_INT8 && dst_r == FMT_FP32) op_nxt = OP_I8_F32;
    else if (src_r == FMT_FP32 && dst_r == FMT_BF16) op_nxt = OP_F32_BF16;
    else if (src_r == FMT_BF16 && dst_r == FMT_FP32) op_nxt = OP_BF16_F32;
    else if (src_r == FMT_INT8 && dst_r == FMT_FP16) op_nxt = OP_I8_F16;
    else op_nxt = OP_BAD;
  end

  // stage 2: normalize int8 magnitude or fp16 denormal mantissa
  logic [10:0] mag;
  logic [3:0]  pos;
  logic [22:0] frac;
  logic [31:0] x2_r;
  logic [3:0]  pos2_r;
  logic [22:0] frac2_r;
  always_comb begin
    if (op1_r == OP_I8_F32 || op1_r == OP_I8_F16)
      mag = {3'd0, x1_r[7] ? 8'(~x1_r[7:0] + 8'd1) : x1_r[7:0]};
    else
      mag = {1'b0, x1_r[9:0]};
  end
  ffc_norm u_norm (.mag(mag), .pos(pos), .frac(frac));

  // stage 3: assemble result
  logic [31:0] i8f, r_nxt, r3_r;
  logic [7:0]  hexp;
  logic        bad3_r;
  always_comb begin
    i8f = 32'd0;
    if (x2_r[7:0] != 8'd0)
      i8f = {x2_r[7], 8'(8'd127 + {4'd0, pos2_r}), frac2_r};
    hexp = 8'(8'd103 + {4'd0, pos2_r});
    unique case (op2_r)
      OP_PASS:     r_nxt = x2_r;
      OP_F32_F16:  r_nxt = {16'd0, f32_to_f16(x2_r)};
      OP_F16_F32: begin
        if (x2_r[14:10] == 5'd0)
          r_nxt = (x2_r[9:0] == 10'd0) ? {x2_r[15], 31'd0} : {x2_r[15], hexp, frac2_r};
        else if (x2_r[14:10] == 5'h1F)
          r_nxt = {x2_r[15], 8'hFF, x2_r[9:0], 13'd0};
        else
          r_nxt = {x2_r[15], 8'(x2_r[14:10] + 8'd112), x2_r[9:0], 13'd0};
      end
      OP_I8_F32:   r_nxt = i8f;
      OP_F32_BF16: r_nxt = {16'd0, x2_r[31:16]};
      OP_BF16_F32: r_nxt = {x2_r[15:0], 16'd0};
      OP_I8_F16:   r_nxt = {16'd0, f32_to_f16(i8f)};
      default:     r_nxt = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r    <= in_ch.value & mask;
      op1_r   <= op_nxt;
      x2_r    <= x1_r;
      op2_r   <= op1_r;
      pos2_r  <= pos;
      frac2_r <= frac;
      r3_r    <= r_nxt;
      bad3_r  <= (op2_r == OP_BAD);
    end
  end

  assign out_ch.valid = v3_r;
  assign out_ch.value = r3_r;
  assign out_ch.unsupported = bad3_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out_ch.ready |=> v3_r && $stable(r3_r)) else $error("result lost under stall");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && bad3_r |-> r3_r == 32'd0) else $error("unsupported word not zero");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v2_r |=> v3_r) else $error("word dropped in pipe");
endmodule

// File: tb/float_format_cast_unit_tb.sv
// testbench for the float format cast unit: directed and random words checked against a predictor
module float_format_cast_unit_tb;
  import ffc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_SRC;
  logic [FmtW-1:0] cfg_data = '0;

  ffc_if in_ch ();
  ffc_if out_ch ();

  float_format_cast_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  typedef struct packed {
    logic [31:0] value;
    logic        unsupported;
  } cast_word_t;

  logic [31:0] pending_words[$];
  cast_word_t  expected_casts[$];
  logic [2:0]  src_fmt, dst_fmt;
  bit          idle_ok;      // random idling enabled
  int          errors;
  longint      cycles;

  // fp32 to fp16 with truncation, flush of fp32 denormals, quiet nan payload
  function automatic logic [15:0] half_of_single(logic [31:0] x);
    logic [7:0]  ex;
    logic [22:0] man;
    logic [15:0] s;
    int          ne;
    logic [23:0] full;
    begin
      ex = x[30:23];
      man = x[22:0];
      s = {x[31], 15'd0};
      ne = int'(ex) - 112;
      full = {1'b1, man};
      if (ex == 8'd0) return s;
      if (ex == 8'hFF) return s | 16'h7C00 | ((man != 0) ? 16'h0200 : 16'h0);
      if (ne >= 31) return s | 16'h7C00;
      if (ne <= 0) begin
        if (ne >= -10) return s | (16'(full >> (14 - ne)) & 16'h03FF);
        return s;
      end
      return s | 16'(ne << 10) | 16'(man >> 13);
    end
  endfunction

  // exact widening of a half, denormals normalized
  function automatic logic [31:0] single_of_half(logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [31:0] s;
    int          shifts;
    begin
      ex = h[14:10];
      man = h[9:0];
      s = {h[15], 31'd0};
      shifts = 0;
      if (ex == 0) begin
        if (man == 0) return s;
        while (man[9] == 1'b0 && shifts < 10) begin
          man = man << 1;
          shifts++;
        end
        man = man << 1;
        return s | (32'(112 - shifts) << 23) | (32'(man) << 13);
      end
      if (ex == 5'h1F) return s | 32'h7F800000 | (32'(man) << 13);
      return s | (32'(ex + 112) << 23) | (32'(man) << 13);
    end
  endfunction

  // signed byte to fp32, exact
  function automatic logic [31:0] single_of_byte(logic [7:0] b);
    logic [8:0] mag;
    int         p;
    begin
      mag = b[7] ? 9'(9'd256 - b) : {1'b0, b};
      p = 0;
      if (mag == 0) return 32'd0;
      while (p < 7 && (mag >> (p + 1)) != 0) p++;
      return {b[7], 8'(127 + p), 23'((32'(mag) << (23 - p)) & 32'h7FFFFF)};
    end
  endfunction

  function automatic cast_word_t cast_of(logic [31:0] x);
    cast_word_t r;
    begin
      r = '0;
      if (src_fmt == dst_fmt) begin
        if (src_fmt == FMT_FP16 || src_fmt == FMT_BF16) r.value = {16'd0, x[15:0]};
        else if (src_fmt == FMT_INT8) r.value = {24'd0, x[7:0]};
        else r.value = x;
      end else if (src_fmt == FMT_FP32 && dst_fmt == FMT_FP16)
        r.value = {16'd0, half_of_single(x)};
      else if (src_fmt == FMT_FP16 && dst_fmt == FMT_FP32)
        r.value = single_of_half(x[15:0]);
      else if (src_fmt == FMT_INT8 && dst_fmt == FMT_FP32)
        r.value = single_of_byte(x[7:0]);
      else if (src_fmt == FMT_FP32 && dst_fmt == FMT_BF16)
        r.value = {16'd0, x[31:16]};
      else if (src_fmt == FMT_BF16 && dst_fmt == FMT_FP32)
        r.value = {x[15:0], 16'd0};
      else if (src_fmt == FMT_INT8 && dst_fmt == FMT_FP16)
        r.value = {16'd0, half_of_single(single_of_byte(x[7:0]))};
      else r.unsupported = 1'b1;
      return r;
    end
  endfunction

  // driver: expectation is computed at acceptance with the current formats
  initial begin
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.unsupported = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_casts.push_back(cast_of(in_ch.value));
      void'(pending_words.pop_front());
    end
    // a waiting word stays put; otherwise take the next one from the queue head
    if (in_ch.valid && !in_ch.ready) begin
      in_ch.valid <= 1'b1;
    end else if (pending_words.size() > 0 && rst_n &&
        !(idle_ok && $urandom_range(99) < 15)) begin
      in_ch.valid <= 1'b1;
      in_ch.value <= pending_words[0];
    end else begin
      in_ch.valid <= 1'b0;
    end
    out_ch.ready <= rst_n && !(idle_ok && $urandom_range(99) < 15);
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_casts.size() == 0) begin
        $display("%0t: unexpected word value=%h unsupported=%b", $time,
                 out_ch.value, out_ch.unsupported);
        errors++;
      end else begin
        cast_word_t e;
        e = expected_casts.pop_front();
        if (out_ch.value !== e.value) begin
          $display("%0t: value expected %h actual %h", $time, e.value, out_ch.value);
          errors++;
        end
        if (out_ch.unsupported !== e.unsupported) begin
          $display("%0t: unsupported expected %b actual %b", $time, e.unsupported,
                   out_ch.unsupported);
          errors++;
        end
      end
    end
    if (cycles > 400000) begin
      $display("float_format_cast_unit_tb: errors");
      $finish;
    end
  end

  // wait until all queued words are sent and answered, then let the pipe settle
  task automatic drain();
    while (pending_words.size() != 0 || in_ch.valid || expected_casts.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_formats(logic [2:0] s, logic [2:0] d);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SRC;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= CFG_DST;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    src_fmt = s;
    dst_fmt = d;
  endtask

  // random word biased toward interesting exponents when the source format is fp32 or fp16
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          k;
    begin
      w = $urandom;
      k = $urandom_range(9);
      if (src_fmt == FMT_FP32) begin
        if (k < 5) w[30:23] = 8'($urandom_range(97, 145));   // around half range
        else if (k == 5) w[30:23] = 8'h00;
        else if (k == 6) w[30:23] = 8'hFF;
      end else if (src_fmt == FMT_FP16) begin
        if (k == 5) w[14:10] = 5'h00;
        else if (k == 6) w[14:10] = 5'h1F;
      end
      return w;
    end
  endfunction

  localparam logic [31:0] DIRECTED[20] = '{
    32'h00000000, 32'h80000000, 32'h007FFFFF, 32'h7F800000, 32'hFF800000,
    32'h7FC00001, 32'h477FE000, 32'h47800000, 32'h38800000, 32'h387FFFFF,
    32'h33800000, 32'h33000000, 32'h3F800000, 32'hFFFFFFFF, 32'h00000001,
    32'h00007C00, 32'h000003FF, 32'h0000FC01, 32'h00000080, 32'h0000007F
  };

  // legal pairs plus meaningless codes and the extremes 0 and 7
  initial begin
    logic [2:0] s, d;
    errors = 0;
    cycles = 0;
    idle_ok = 1'b0;
    src_fmt = FMT_FP32;
    dst_fmt = FMT_FP32;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under reset formats and under each selected pair
    for (int i = 0; i < 20; i++) pending_words.push_back(DIRECTED[i]);
    for (int si = 0; si < 8; si++) begin
      for (int di = 0; di < 8; di++) begin
        if ((si >= 1 && si <= 4 && di >= 1 && di <= 4) || si == di ||
            (si + di) % 5 == 0) begin
          set_formats(3'(si), 3'(di));
          for (int i = 0; i < 20; i++) pending_words.push_back(DIRECTED[i]);
        end
      end
    end

    // random phases: no idling in the first one
    for (int ph = 0; ph < 20; ph++) begin
      if ($urandom_range(9) < 8) begin
        s = 3'($urandom_range(1, 4));
        d = 3'($urandom_range(1, 4));
      end else begin
        s = 3'($urandom);
        d = 3'($urandom);
      end
      set_formats(s, d);
      idle_ok = (ph != 0);
      for (int i = 0; i < 50; i++) pending_words.push_back(random_word());
    end
    drain();

    if (errors == 0) $display("float_format_cast_unit_tb: clean");
    else $display("float_format_cast_unit_tb: errors");
    $finish;
  end
endmodule
